FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the merger RTL; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/arsm_pkg.sv
// Types and constants for the adjacent region similarity merger.
package arsm_pkg;

  localparam int ADDR_BITS  = 48;
  localparam int COUNT_BITS = 16;
  localparam int THR_BITS   = 16;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(100);

  // Deviation is scaled by two times per-mille
  localparam int PERMILLE       = 1000;
  localparam int DEV_SCALE      = 2 * PERMILLE;
  localparam int DEV_SCALE_BITS = $clog2(DEV_SCALE + 1);
  localparam int DEV_PROD_BITS  = COUNT_BITS + DEV_SCALE_BITS;
  localparam int LIM_PROD_BITS  = THR_BITS + 1 + COUNT_BITS;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  in_start;
    logic [ADDR_BITS-1:0]  in_end;
    logic [COUNT_BITS-1:0] in_count;
    logic                  in_last;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  out_start;
    logic [ADDR_BITS-1:0]  out_end;
    logic [COUNT_BITS-1:0] out_count;
    logic                  out_last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic room_ok;
  } dp_status_t;

endpackage

FILE: hw/rtl/adjacent_region_similarity_merger.sv
// Adjacent region similarity merger: takes address-ordered regions one item
// at a time and merges contiguous ones with similar access counts. For each
// item, in the accept cycle the average count, the scaled deviation and the
// threshold limit are computed and registered (one multiplier each for the
// deviation and the limit); in the decide state the comparison is made, the
// pending region is updated and up to two results are written to a two-entry
// output queue. The decide state repeats while the queue lacks room for the
// item's results, and no new item is accepted until the current one commits.
// The threshold (per-mille, reset 100) is to be written through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce this.
module adjacent_region_similarity_merger (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [arsm_pkg::THR_BITS-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  arsm_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output arsm_pkg::out_item_t           out_item
);
  import arsm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  arsm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .status  (status)
  );

  arsm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

FILE: hw/rtl/arsm_outq.sv
// Two-entry result queue that takes up to two items per cycle.
`include "assert_macros.svh"

module arsm_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_n,
  input  arsm_pkg::out_item_t push0,
  input  arsm_pkg::out_item_t push1,
  output logic [1:0]         q_cnt,
  output logic               out_valid,
  input  logic               out_ready,
  output arsm_pkg::out_item_t out_item
);
  import arsm_pkg::*;

  out_item_t  q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_item  = q[rd_ptr];
  assign q_cnt     = cnt;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      wr_ptr <= wr_ptr ^ push_n[0];
      rd_ptr <= rd_ptr ^ pop;
      cnt    <= cnt + push_n - {1'b0, pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      q[~wr_ptr] <= push1;
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, ({1'b0, cnt} + {1'b0, push_n}) <= 3'd2,
                 "result queue overflow")
  `ASSERT_NEXT(a_push_shows, (cnt == 2'd0) && (push_n != 2'd0), out_valid,
               "pushed item not presented")

endmodule

FILE: hw/rtl/arsm_datapath.sv
// Datapath: threshold, pending region, similarity test and result queue.
module arsm_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [arsm_pkg::THR_BITS-1:0] cfg_wr_data,
  input  arsm_pkg::in_item_t          in_item,
  input  arsm_pkg::dp_cmd_t           cmd,
  output arsm_pkg::dp_status_t        status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output arsm_pkg::out_item_t         out_item
);
  import arsm_pkg::*;

  logic [THR_BITS-1:0]   thr;

  // Pending region
  logic                  pend_valid;
  logic [ADDR_BITS-1:0]  pend_start;
  logic [ADDR_BITS-1:0]  pend_end;
  logic [COUNT_BITS-1:0] pend_count;

  // Captured item and results registered at capture
  in_item_t                 itm;
  logic                     contig;
  logic [COUNT_BITS-1:0]    avg;
  logic                     avg_zero;
  logic [DEV_PROD_BITS-1:0] prod_dev;
  logic [LIM_PROD_BITS-1:0] prod_lim;

  logic [COUNT_BITS:0]      sum_c;
  logic [COUNT_BITS-1:0]    avg_c;
  logic [COUNT_BITS-1:0]    dev_c;
  logic [THR_BITS:0]        thr_p1;

  logic                     similar;
  logic                     merge;
  logic [1:0]               need;
  logic [1:0]               push_n;
  logic [1:0]               q_cnt;
  out_item_t                push0;
  out_item_t                push1;
  out_item_t                flush_item;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // Average and deviation against the pending count
  always_comb begin
    sum_c  = {1'b0, pend_count} + {1'b0, in_item.in_count};
    avg_c  = sum_c[COUNT_BITS:1];
    dev_c  = (in_item.in_count > avg_c) ? (in_item.in_count - avg_c)
                                         : (avg_c - in_item.in_count);
    thr_p1 = {1'b0, thr} + {{THR_BITS{1'b0}}, 1'b1};
  end

  // Capture: floor(dev*2000/avg) <= thr  <=>  dev*2000 < (thr+1)*avg
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      itm      <= in_item;
      contig   <= pend_valid && (pend_end == in_item.in_start);
      avg      <= avg_c;
      avg_zero <= (avg_c == '0);
      prod_dev <= DEV_PROD_BITS'(dev_c) * DEV_PROD_BITS'(DEV_SCALE);
      prod_lim <= LIM_PROD_BITS'(thr_p1) * LIM_PROD_BITS'(avg_c);
    end
  end

  // Decision and the results it emits
  always_comb begin
    similar = avg_zero || (LIM_PROD_BITS'(prod_dev) < prod_lim);
    merge   = contig && similar;

    flush_item.out_start = merge ? pend_start : itm.in_start;
    flush_item.out_end   = itm.in_end;
    flush_item.out_count = merge ? avg : itm.in_count;
    flush_item.out_last  = 1'b1;

    push1 = flush_item;
    if (merge || !pend_valid) begin
      push0 = flush_item;
      need  = {1'b0, itm.in_last};
    end else begin
      push0.out_start = pend_start;
      push0.out_end   = pend_end;
      push0.out_count = pend_count;
      push0.out_last  = 1'b0;
      need            = {1'b0, itm.in_last} + 2'd1;
    end

    status.room_ok = ({1'b0, need} + {1'b0, q_cnt}) <= 3'd2;
    push_n         = cmd.commit ? need : 2'd0;
  end

  // Pending region update
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.commit) begin
      pend_valid <= !itm.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (merge) begin
        pend_end   <= itm.in_end;
        pend_count <= avg;
      end else begin
        pend_start <= itm.in_start;
        pend_end   <= itm.in_end;
        pend_count <= itm.in_count;
      end
    end
  end

  arsm_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .push0    (push0),
    .push1    (push1),
    .q_cnt    (q_cnt),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

FILE: hw/rtl/arsm_ctrl.sv
// Controller: accepts an item, then commits its decision when the queue has room.
`include "assert_macros.svh"

module arsm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output arsm_pkg::dp_cmd_t    cmd,
  input  arsm_pkg::dp_status_t status
);
  import arsm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DECIDE
  } state_t;

  state_t state;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == S_DECIDE) && status.room_ok;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (status.room_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_capture_decides, cmd.capture, !in_ready && !cmd.capture,
               "item accepted while another is being decided")
  `ASSERT_NEXT(a_commit_frees, cmd.commit, in_ready,
               "not ready after commit")

endmodule
